>>> design/upcp_pkg.sv
// Shared types and constants for the UART PWM command parser.
package upcp_pkg;

    localparam int LINE_BYTES = 32;
    localparam int LEN_W = $clog2(LINE_BYTES);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] FULL_SCALE_RESET = 16'd1023;
    localparam logic [8:0] MAG_CAP = 9'd256;
    localparam logic [7:0] MAG_MAX = 8'd255;
    localparam logic [16:0] RECIP_255 = 17'd65793;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic       neg;
        logic [7:0] mag;
    } t_cmd;

endpackage

>>> design/upcp_front.sv
// Front end: parses received bytes and queues one command per finished line.
module upcp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    output logic               o_push,
    output upcp_pkg::t_cmd     o_cmd
);

    upcp_pkg::t_phase r_phase, n_phase;
    logic [upcp_pkg::LEN_W-1:0] r_len, n_len;
    logic r_neg, n_neg;
    logic [8:0] r_acc, n_acc;

    logic is_term, is_digit, is_space, is_sign;
    logic [11:0] acc_mul;
    logic [7:0] mag_clamped;

    assign is_term = (i_rx_byte == upcp_pkg::CH_LF) || (i_rx_byte == upcp_pkg::CH_CR);
    assign is_digit = (i_rx_byte >= upcp_pkg::CH_ZERO) && (i_rx_byte <= upcp_pkg::CH_NINE);
    assign is_space = (i_rx_byte == upcp_pkg::CH_SPACE) || (i_rx_byte == upcp_pkg::CH_TAB)
                   || (i_rx_byte == upcp_pkg::CH_VT) || (i_rx_byte == upcp_pkg::CH_FF);
    assign is_sign = (i_rx_byte == upcp_pkg::CH_PLUS) || (i_rx_byte == upcp_pkg::CH_MINUS);
    assign acc_mul = ({3'b000, r_acc} * 12'd10)
                   + {4'b0000, i_rx_byte - upcp_pkg::CH_ZERO};
    assign mag_clamped = (r_acc > {1'b0, upcp_pkg::MAG_MAX}) ? upcp_pkg::MAG_MAX : r_acc[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upcp_pkg::PH_SPACE;
            r_len <= '0;
            r_neg <= 1'b0;
            r_acc <= '0;
        end else begin
            r_phase <= n_phase;
            r_len <= n_len;
            r_neg <= n_neg;
            r_acc <= n_acc;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_len = r_len;
        n_neg = r_neg;
        n_acc = r_acc;
        o_push = 1'b0;
        o_cmd.mag = mag_clamped;
        o_cmd.neg = r_neg && (mag_clamped != 8'd0);
        if (i_accept) begin
            if (is_term || (r_len >= upcp_pkg::LEN_W'(upcp_pkg::LINE_BYTES - 1))) begin
                o_push = is_term && (r_len != '0);
                n_phase = upcp_pkg::PH_SPACE;
                n_len = '0;
                n_neg = 1'b0;
                n_acc = '0;
            end else begin
                n_len = r_len + 1'b1;
                if (r_phase != upcp_pkg::PH_DONE) begin
                    priority if (is_digit) begin
                        n_acc = (acc_mul > {3'b000, upcp_pkg::MAG_CAP})
                              ? upcp_pkg::MAG_CAP : acc_mul[8:0];
                        n_phase = upcp_pkg::PH_DIGITS;
                    end else if (r_phase == upcp_pkg::PH_SPACE && is_space) begin
                        n_phase = upcp_pkg::PH_SPACE;
                    end else if (r_phase == upcp_pkg::PH_SPACE && is_sign) begin
                        n_neg = (i_rx_byte == upcp_pkg::CH_MINUS);
                        n_phase = upcp_pkg::PH_SIGN;
                    end else begin
                        n_phase = upcp_pkg::PH_DONE;
                    end
                end
            end
        end
    end

endmodule

>>> design/upcp_fifo.sv
// Command queue between the parser and the compare pipeline.
module upcp_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  upcp_pkg::t_cmd     i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_nonempty,
    output upcp_pkg::t_cmd     o_data
);

    upcp_pkg::t_cmd r_mem [upcp_pkg::FIFO_DEPTH];
    logic [upcp_pkg::PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [upcp_pkg::CNT_W-1:0] r_count;
    logic do_push, do_pop;

    assign o_full = (r_count == upcp_pkg::CNT_W'(upcp_pkg::FIFO_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_nonempty;
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == upcp_pkg::PTR_W'(upcp_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == upcp_pkg::PTR_W'(upcp_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/upcp_back.sv
// Back end: full scale register and pipeline from command to PWM compare value.
module upcp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_cmd_valid,
    input  upcp_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [8:0]  o_signed_command,
    output logic               o_drive_forward,
    output logic               o_drive_reverse,
    output logic [15:0]        o_duty_count
);

    logic [15:0] r_full_scale;
    logic advance;

    logic r_s1_valid;
    upcp_pkg::t_cmd r_s1_cmd;
    logic [23:0] r_s1_prod;

    logic r_s2_valid;
    upcp_pkg::t_cmd r_s2_cmd;
    logic [23:0] r_s2_prod;
    logic [15:0] r_s2_quot;

    logic r_out_valid;
    logic signed [8:0] r_out_cmd;
    logic r_out_fwd, r_out_rev;
    logic [15:0] r_out_pwm;

    logic [40:0] recip_prod;
    logic [23:0] remainder;
    logic [15:0] quot_fixed;

    assign advance = !r_out_valid || !i_out_stall;
    assign o_pop = advance;
    assign recip_prod = {17'd0, r_s1_prod} * {24'd0, upcp_pkg::RECIP_255};
    assign remainder = r_s2_prod - {r_s2_quot, 8'd0} + {8'd0, r_s2_quot};
    assign quot_fixed = (remainder >= 24'd255) ? r_s2_quot + 1'b1 : r_s2_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= upcp_pkg::FULL_SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_full_scale <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_cmd_valid;
            r_s2_valid <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_cmd <= i_cmd;
            r_s1_prod <= {16'd0, i_cmd.mag} * {8'd0, r_full_scale};
            r_s2_cmd <= r_s1_cmd;
            r_s2_prod <= r_s1_prod;
            r_s2_quot <= recip_prod[39:24];
            r_out_cmd <= r_s2_cmd.neg ? -$signed({1'b0, r_s2_cmd.mag})
                                      : $signed({1'b0, r_s2_cmd.mag});
            r_out_fwd <= !r_s2_cmd.neg && (r_s2_cmd.mag != 8'd0);
            r_out_rev <= r_s2_cmd.neg;
            r_out_pwm <= quot_fixed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_signed_command = r_out_cmd;
    assign o_drive_forward = r_out_fwd;
    assign o_drive_reverse = r_out_rev;
    assign o_duty_count = r_out_pwm;

endmodule

>>> design/uart_pwm_command_parser_core.sv
// Top level of the UART PWM command parser.
// Takes one received byte per clock cycle; the input stalls only while the
// four-entry command queue is full. Each CR or LF that closes a non-empty line
// queues one command, which passes from the head of the queue through the full
// scale multiply, the reciprocal multiply that divides by 255, and the remainder
// correction, each registered in turn. One result can be delivered per cycle
// while the output is not stalled. The full scale register is written through
// its own port, which is always ready; write it only while no line is in flight.
module uart_pwm_command_parser_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [8:0] o_signed_command,
    output logic              o_drive_forward,
    output logic              o_drive_reverse,
    output logic [15:0]       o_duty_count
);

    logic in_accept;
    logic push, pop, fifo_full, fifo_nonempty;
    upcp_pkg::t_cmd push_cmd, head_cmd;

    assign o_in_stall = fifo_full;
    assign in_accept = i_in_valid && !fifo_full;
    assign o_cfg_ready = 1'b1;

    upcp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    upcp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_cmd),
        .i_pop      (pop),
        .o_full     (fifo_full),
        .o_nonempty (fifo_nonempty),
        .o_data     (head_cmd)
    );

    upcp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_cmd_valid      (fifo_nonempty),
        .i_cmd            (head_cmd),
        .o_pop            (pop),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_signed_command (o_signed_command),
        .o_drive_forward  (o_drive_forward),
        .o_drive_reverse  (o_drive_reverse),
        .o_duty_count     (o_duty_count)
    );

endmodule
